@@ rtl/core/second_chance_frame_table_core_macros.svh @@
// Assertion macros for the second-chance frame table checker.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef SECOND_CHANCE_FRAME_TABLE_CORE_MACROS_SVH
`define SECOND_CHANCE_FRAME_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SCFT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame table check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SCFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame table check failed");

`endif

@@ rtl/core/scft_pkg.sv @@
// Shared types and constants of the second-chance frame table.
// Used by every module of the block; depends on nothing.
package scft_pkg;

    localparam int FRAME_COUNT   = 64;
    localparam int PAGE_TAG_BITS = 20;
    localparam int OWNER_BITS    = 8;
    localparam int FRAME_BITS    = $clog2(FRAME_COUNT);
    localparam int CNT_BITS      = $clog2(FRAME_COUNT + 1);
    localparam int ITER_BITS     = CNT_BITS + 1;
    localparam int POOL_BITS     = 7;
    localparam int CMD_BITS      = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [POOL_BITS-1:0] POOL_RESET = POOL_BITS'(64);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_LOOKUP     = 3'd1,
        CMD_PIN        = 3'd2,
        CMD_UNPIN      = 3'd3,
        CMD_FREE       = 3'd4,
        CMD_FREE_OWNER = 3'd5,
        CMD_TOUCH      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_NOFRAME = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ACT_DROP = 2'd0,
        ACT_SWAP = 2'd1,
        ACT_FILE = 2'd2
    } act_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]      cmd;
        logic [PAGE_TAG_BITS-1:0] tag;
        logic [OWNER_BITS-1:0]    owner;
        logic [FRAME_BITS-1:0]    fidx;
        logic                     file;
        logic                     wr;
    } item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [FRAME_BITS-1:0]    frame;
        logic                     victim_valid;
        logic [PAGE_TAG_BITS-1:0] victim_page;
        logic [OWNER_BITS-1:0]    victim_owner;
        logic [1:0]               victim_action;
    } res_t;

endpackage

@@ rtl/core/scft_front.sv @@
// Front end of the frame table: takes command words and queues them.
// Depends on scft_pkg.
module scft_front import scft_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CMD_BITS-1:0]      command,
    input  logic [PAGE_TAG_BITS-1:0] page_tag,
    input  logic [OWNER_BITS-1:0]    owner_id,
    input  logic [FRAME_BITS-1:0]    frame_index,
    input  logic                     file_backed,
    input  logic                     is_write,
    output logic                     busy,
    output logic                     item_valid,
    output item_t                    item,
    input  logic                     item_pop
);

    localparam int QB = $clog2(QUEUE_DEPTH);

    item_t            queue_reg [QUEUE_DEPTH];
    logic [QB-1:0]    wptr_reg;
    logic [QB-1:0]    rptr_reg;
    logic [QB:0]      fill_reg;
    logic             push;
    logic             pop;
    item_t            in_item;

    always_comb
    begin
        in_item.cmd   = command;
        in_item.tag   = page_tag;
        in_item.owner = owner_id;
        in_item.fidx  = frame_index;
        // Only allocate keeps the file flag and only touch keeps the write flag.
        in_item.file  = file_backed && (cmd_t'(command) == CMD_ALLOC);
        in_item.wr    = is_write && (cmd_t'(command) == CMD_TOUCH);
    end

    assign busy       = (fill_reg == (QB+1)'(QUEUE_DEPTH));
    assign item_valid = (fill_reg != '0);
    assign item       = queue_reg[rptr_reg];
    assign push       = start && !busy;
    assign pop        = item_pop && item_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == QB'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == QB'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/scft_back.sv @@
// Back end of the frame table: the frame pool, the age-ordered linked list
// and the sequencer that walks it. Depends on scft_pkg.
module scft_back import scft_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  item_t                 item,
    output logic                  item_pop,
    input  logic                  cfg_wr_en,
    input  logic [POOL_BITS-1:0]  cfg_wr_data,
    output logic                  done,
    output res_t                  res,
    output logic [CNT_BITS-1:0]   total_count,
    output logic [CNT_BITS-1:0]   pinned_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SC_RD,
        S_SC_EV,
        S_WK_RD,
        S_WK_EV,
        S_FO_RD,
        S_FO_EV,
        S_RM_RD,
        S_UNLINK,
        S_APPEND
    } state_t;

    state_t                    state_reg;
    item_t                     op_reg;
    logic [POOL_BITS-1:0]      pool_reg;
    logic [FRAME_COUNT-1:0]    busy_reg;
    logic [FRAME_COUNT-1:0]    valid_reg;
    logic [FRAME_COUNT-1:0]    pin_reg;
    logic [FRAME_COUNT-1:0]    acc_reg;
    logic [FRAME_COUNT-1:0]    dirty_reg;
    logic [FRAME_COUNT-1:0]    file_reg;
    logic [FRAME_BITS-1:0]     head_reg;
    logic [FRAME_BITS-1:0]     tail_reg;
    logic [CNT_BITS-1:0]       len_reg;
    logic [CNT_BITS-1:0]       pinned_reg;
    logic [FRAME_BITS-1:0]     cur_reg;
    logic [FRAME_BITS-1:0]     k_reg;
    logic [ITER_BITS-1:0]      iter_reg;
    logic [CNT_BITS-1:0]       left_reg;
    logic                      done_reg;
    res_t                      res_reg;

    logic [PAGE_TAG_BITS-1:0]  page_mem  [FRAME_COUNT];
    logic [OWNER_BITS-1:0]     owner_mem [FRAME_COUNT];
    logic [FRAME_BITS-1:0]     next_mem  [FRAME_COUNT];
    logic [FRAME_BITS-1:0]     prev_mem  [FRAME_COUNT];
    logic [PAGE_TAG_BITS-1:0]  rd_page_reg;
    logic [OWNER_BITS-1:0]     rd_owner_reg;
    logic [FRAME_BITS-1:0]     rd_next_reg;
    logic [FRAME_BITS-1:0]     rd_prev_reg;

    logic                      ent_we;
    logic                      nxt_we;
    logic [FRAME_BITS-1:0]     nxt_wa;
    logic [FRAME_BITS-1:0]     nxt_wd;
    logic                      prv_we;
    logic [FRAME_BITS-1:0]     prv_wa;
    logic [FRAME_BITS-1:0]     prv_wd;

    logic [CNT_BITS-1:0]       pool_lim;
    logic                      free_found;
    logic [FRAME_BITS-1:0]     free_idx;
    logic [1:0]                cur_action;

    assign item_pop     = (state_reg == S_IDLE) && item_valid;
    assign done         = done_reg;
    assign res          = res_reg;
    assign total_count  = len_reg;
    assign pinned_count = pinned_reg;

    // The pool register is used saturated to the number of frames.
    assign pool_lim = (32'(pool_reg) > FRAME_COUNT) ? CNT_BITS'(FRAME_COUNT)
                                                    : CNT_BITS'(pool_reg);

    // Lowest free frame below the pool limit.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--)
        begin
            if ((i < int'(pool_lim)) && !busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = FRAME_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (dirty_reg[cur_reg])
        begin
            cur_action = ACT_SWAP;
        end
        else if (file_reg[cur_reg])
        begin
            cur_action = ACT_FILE;
        end
        else
        begin
            cur_action = ACT_DROP;
        end
    end

    // List pointer writes: unlink splices the neighbors, append links at the tail.
    always_comb
    begin
        ent_we = 1'b0;
        nxt_we = 1'b0;
        nxt_wa = rd_prev_reg;
        nxt_wd = rd_next_reg;
        prv_we = 1'b0;
        prv_wa = rd_next_reg;
        prv_wd = rd_prev_reg;
        case (state_reg)
            S_UNLINK:
            begin
                nxt_we = (cur_reg != head_reg);
                prv_we = (cur_reg != tail_reg);
            end
            S_APPEND:
            begin
                ent_we = 1'b1;
                prv_we = 1'b1;
                prv_wa = k_reg;
                prv_wd = tail_reg;
                nxt_we = (len_reg != '0);
                nxt_wa = tail_reg;
                nxt_wd = k_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            page_mem[k_reg]  <= op_reg.tag;
            owner_mem[k_reg] <= op_reg.owner;
        end
        if (nxt_we)
        begin
            next_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prev_mem[prv_wa] <= prv_wd;
        end
        rd_page_reg  <= page_mem[cur_reg];
        rd_owner_reg <= owner_mem[cur_reg];
        rd_next_reg  <= next_mem[cur_reg];
        rd_prev_reg  <= prev_mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pool_reg   <= POOL_RESET;
            busy_reg   <= '0;
            valid_reg  <= '0;
            pin_reg    <= '0;
            acc_reg    <= '0;
            dirty_reg  <= '0;
            file_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            len_reg    <= '0;
            pinned_reg <= '0;
            cur_reg    <= '0;
            k_reg      <= '0;
            iter_reg   <= '0;
            left_reg   <= '0;
            done_reg   <= 1'b0;
            res_reg    <= '0;
            op_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                pool_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        op_reg    <= item;
                        res_reg   <= '0;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    case (op_reg.cmd)
                        CMD_ALLOC:
                        begin
                            if (free_found)
                            begin
                                k_reg     <= free_idx;
                                state_reg <= S_APPEND;
                            end
                            else if (len_reg == '0)
                            begin
                                res_reg.status <= ST_NOFRAME;
                                done_reg       <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                cur_reg   <= head_reg;
                                iter_reg  <= '0;
                                state_reg <= S_SC_RD;
                            end
                        end
                        CMD_LOOKUP, CMD_TOUCH:
                        begin
                            if (len_reg == '0)
                            begin
                                res_reg.status <= ST_MISS;
                                done_reg       <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                cur_reg   <= head_reg;
                                left_reg  <= len_reg;
                                state_reg <= S_WK_RD;
                            end
                        end
                        CMD_PIN, CMD_UNPIN:
                        begin
                            if (!valid_reg[op_reg.fidx])
                            begin
                                res_reg.status <= ST_MISS;
                            end
                            else if (op_reg.cmd == CMD_PIN && !pin_reg[op_reg.fidx])
                            begin
                                pin_reg[op_reg.fidx] <= 1'b1;
                                pinned_reg           <= pinned_reg + 1'b1;
                            end
                            else if (op_reg.cmd == CMD_UNPIN && pin_reg[op_reg.fidx])
                            begin
                                pin_reg[op_reg.fidx] <= 1'b0;
                                pinned_reg           <= pinned_reg - 1'b1;
                            end
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        CMD_FREE:
                        begin
                            if (!valid_reg[op_reg.fidx])
                            begin
                                res_reg.status <= ST_MISS;
                                done_reg       <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                cur_reg   <= op_reg.fidx;
                                state_reg <= S_RM_RD;
                            end
                        end
                        CMD_FREE_OWNER:
                        begin
                            if (len_reg == '0)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                cur_reg   <= head_reg;
                                left_reg  <= len_reg;
                                state_reg <= S_FO_RD;
                            end
                        end
                        default:
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_SC_RD:
                begin
                    state_reg <= S_SC_EV;
                end

                S_SC_EV:
                begin
                    if (!pin_reg[cur_reg] && !acc_reg[cur_reg])
                    begin
                        res_reg.victim_valid  <= 1'b1;
                        res_reg.victim_page   <= rd_page_reg;
                        res_reg.victim_owner  <= rd_owner_reg;
                        res_reg.victim_action <= cur_action;
                        k_reg                 <= cur_reg;
                        state_reg             <= S_UNLINK;
                    end
                    else
                    begin
                        // A set accessed bit is cleared and the entry gets a second chance.
                        if (!pin_reg[cur_reg])
                        begin
                            acc_reg[cur_reg] <= 1'b0;
                        end
                        if (iter_reg + 1'b1 == {len_reg, 1'b0})
                        begin
                            res_reg.status <= ST_NOFRAME;
                            done_reg       <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            iter_reg  <= iter_reg + 1'b1;
                            cur_reg   <= (cur_reg == tail_reg) ? head_reg : rd_next_reg;
                            state_reg <= S_SC_RD;
                        end
                    end
                end

                S_WK_RD:
                begin
                    state_reg <= S_WK_EV;
                end

                S_WK_EV:
                begin
                    if (rd_page_reg == op_reg.tag)
                    begin
                        if (op_reg.cmd == CMD_TOUCH)
                        begin
                            acc_reg[cur_reg] <= 1'b1;
                            if (op_reg.wr)
                            begin
                                dirty_reg[cur_reg] <= 1'b1;
                            end
                        end
                        else
                        begin
                            res_reg.frame <= cur_reg;
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (left_reg == CNT_BITS'(1))
                    begin
                        res_reg.status <= ST_MISS;
                        done_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        left_reg  <= left_reg - 1'b1;
                        cur_reg   <= rd_next_reg;
                        state_reg <= S_WK_RD;
                    end
                end

                S_FO_RD:
                begin
                    state_reg <= S_FO_EV;
                end

                S_FO_EV:
                begin
                    if (rd_owner_reg == op_reg.owner)
                    begin
                        state_reg <= S_UNLINK;
                    end
                    else if (left_reg == CNT_BITS'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        left_reg  <= left_reg - 1'b1;
                        cur_reg   <= rd_next_reg;
                        state_reg <= S_FO_RD;
                    end
                end

                S_RM_RD:
                begin
                    state_reg <= S_UNLINK;
                end

                S_UNLINK:
                begin
                    if (cur_reg == head_reg)
                    begin
                        head_reg <= rd_next_reg;
                    end
                    if (cur_reg == tail_reg)
                    begin
                        tail_reg <= rd_prev_reg;
                    end
                    len_reg <= len_reg - 1'b1;
                    if (pin_reg[cur_reg])
                    begin
                        pinned_reg <= pinned_reg - 1'b1;
                    end
                    valid_reg[cur_reg] <= 1'b0;
                    pin_reg[cur_reg]   <= 1'b0;
                    acc_reg[cur_reg]   <= 1'b0;
                    dirty_reg[cur_reg] <= 1'b0;
                    file_reg[cur_reg]  <= 1'b0;
                    case (op_reg.cmd)
                        CMD_ALLOC:
                        begin
                            // The evicted frame stays busy and is reused at once.
                            state_reg <= S_APPEND;
                        end
                        CMD_FREE_OWNER:
                        begin
                            busy_reg[cur_reg] <= 1'b0;
                            if (left_reg == CNT_BITS'(1))
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                left_reg  <= left_reg - 1'b1;
                                cur_reg   <= rd_next_reg;
                                state_reg <= S_FO_RD;
                            end
                        end
                        default:
                        begin
                            busy_reg[cur_reg] <= 1'b0;
                            done_reg          <= 1'b1;
                            state_reg         <= S_IDLE;
                        end
                    endcase
                end

                S_APPEND:
                begin
                    busy_reg[k_reg]  <= 1'b1;
                    valid_reg[k_reg] <= 1'b1;
                    pin_reg[k_reg]   <= 1'b1;
                    acc_reg[k_reg]   <= 1'b0;
                    dirty_reg[k_reg] <= 1'b0;
                    file_reg[k_reg]  <= op_reg.file;
                    if (len_reg == '0)
                    begin
                        head_reg <= k_reg;
                    end
                    tail_reg      <= k_reg;
                    len_reg       <= len_reg + 1'b1;
                    pinned_reg    <= pinned_reg + 1'b1;
                    res_reg.frame <= k_reg;
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/second_chance_frame_table_core.sv @@
// Top level of the second-chance frame table.
// Depends on scft_pkg, scft_front and scft_back.
//
// Usage: a command word is taken at a rising edge with start high and busy
// low. A two-entry queue sits in front of the execution sequencer, so busy
// rises only when two words wait behind the one in progress. Every word
// gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so results are never held back.
// Lookup and touch walk the linked list in age order; free_owner walks it
// and removes each entry of the owner; allocate with eviction scans the
// list from the head, up to two passes over the table. The walk reads one
// memory entry per step, and the sequencer takes a new word only once the
// result of the previous one is shown; words sent meanwhile wait in the
// queue. The user must write pool_size through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block does not enforce this. Reset
// empties the table, frees every frame and sets pool_size to 64; no
// clearing pass follows it.
module second_chance_frame_table_core import scft_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_BITS-1:0]      command,
    input  logic [PAGE_TAG_BITS-1:0] page_tag,
    input  logic [OWNER_BITS-1:0]    owner_id,
    input  logic [FRAME_BITS-1:0]    frame_index,
    input  logic                     file_backed,
    input  logic                     is_write,
    input  logic                     cfg_wr_en,
    input  logic [POOL_BITS-1:0]     cfg_wr_data,
    output logic                     done,
    output logic [1:0]               status,
    output logic [FRAME_BITS-1:0]    frame_out,
    output logic                     victim_valid,
    output logic [PAGE_TAG_BITS-1:0] victim_page,
    output logic [OWNER_BITS-1:0]    victim_owner,
    output logic [1:0]               victim_action,
    output logic [CNT_BITS-1:0]      total_count,
    output logic [CNT_BITS-1:0]      pinned_count
);

    logic  item_valid;
    item_t item;
    logic  item_pop;
    res_t  res;

    scft_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .page_tag    (page_tag),
        .owner_id    (owner_id),
        .frame_index (frame_index),
        .file_backed (file_backed),
        .is_write    (is_write),
        .busy        (busy),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop)
    );

    scft_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .res          (res),
        .total_count  (total_count),
        .pinned_count (pinned_count)
    );

    assign status        = res.status;
    assign frame_out     = res.frame;
    assign victim_valid  = res.victim_valid;
    assign victim_page   = res.victim_page;
    assign victim_owner  = res.victim_owner;
    assign victim_action = res.victim_action;

endmodule

@@ rtl/core/scft_checker.sv @@
// Port-level checks of the second-chance frame table, bound to the top level.
// Depends on scft_pkg and second_chance_frame_table_core_macros.svh.
`include "second_chance_frame_table_core_macros.svh"

module scft_checker import scft_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     done,
    input logic [1:0]               status,
    input logic                     victim_valid,
    input logic [PAGE_TAG_BITS-1:0] victim_page,
    input logic [1:0]               victim_action,
    input logic [CNT_BITS-1:0]      total_count,
    input logic [CNT_BITS-1:0]      pinned_count
);

    `SCFT_ASSERT_IMPLY(a_pinned_le_total, done, pinned_count <= total_count)
    `SCFT_ASSERT_IMPLY(a_victim_ok, done && victim_valid, status == ST_OK)
    `SCFT_ASSERT_IMPLY(a_no_victim_act, done && !victim_valid, victim_action == ACT_DROP)
    `SCFT_ASSERT_IMPLY(a_no_victim_page, done && !victim_valid, victim_page == '0)
    // Every word passes through the idle and the execute states, so results never abut.
    `SCFT_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

bind second_chance_frame_table_core scft_checker u_scft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .done          (done),
    .status        (status),
    .victim_valid  (victim_valid),
    .victim_page   (victim_page),
    .victim_action (victim_action),
    .total_count   (total_count),
    .pinned_count  (pinned_count)
);
